// File: design/sha1bh_pkg.sv
// sha1bh_pkg: shared types, constants and round functions for the sha-1 block hash core
// no dependencies
`default_nettype none

package sha1bh_pkg;

    localparam int SHA1BH_WORDS       = 16;
    localparam int SHA1BH_ROUNDS      = 80;
    localparam int SHA1BH_DIGEST      = 5;
    localparam int SHA1BH_QUEUE_DEPTH = 2;

    localparam logic [31:0] SHA1BH_IV [SHA1BH_DIGEST] = '{
        32'h6745_2301, 32'hEFCD_AB89, 32'h98BA_DCFE, 32'h1032_5476, 32'hC3D2_E1F0
    };

    localparam logic [6:0] SHA1BH_STAGE1 = 7'd20;
    localparam logic [6:0] SHA1BH_STAGE2 = 7'd40;
    localparam logic [6:0] SHA1BH_STAGE3 = 7'd60;

    typedef struct packed {
        logic [SHA1BH_WORDS-1:0][31:0] words;
        logic                          init;
        logic                          fin;
    } sha1bh_blk_t;

    typedef struct packed {
        logic        valid;
        sha1bh_blk_t blk;
    } sha1bh_push_t;

    function automatic logic [31:0] sha1bh_f(input logic [6:0] rnd, input logic [31:0] b,
                                             input logic [31:0] c, input logic [31:0] d);
        logic [31:0] r;
        if (rnd < SHA1BH_STAGE1)
            r = (b & c) | (~b & d);
        else if (rnd >= SHA1BH_STAGE2 && rnd < SHA1BH_STAGE3)
            r = (b & c) | (b & d) | (c & d);
        else
            r = b ^ c ^ d;
        return r;
    endfunction

    function automatic logic [31:0] sha1bh_k(input logic [6:0] rnd);
        logic [31:0] r;
        if (rnd < SHA1BH_STAGE1)
            r = 32'h5A82_7999;
        else if (rnd < SHA1BH_STAGE2)
            r = 32'h6ED9_EBA1;
        else if (rnd < SHA1BH_STAGE3)
            r = 32'h8F1B_BCDC;
        else
            r = 32'hCA62_C1D6;
        return r;
    endfunction

endpackage

`default_nettype wire

// File: design/sha1bh_front.sv
// sha1bh_front: takes message words, tracks the word position and assembles 16-word blocks
// depends on sha1bh_pkg; pushes finished blocks into sha1bh_fifo
`default_nettype none

module sha1bh_front
    import sha1bh_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         message_valid,
    output logic              message_ready,
    input  wire logic [31:0]  message_word,
    input  wire logic         first_block,
    input  wire logic         end_of_message,
    input  wire logic         queue_full,
    output sha1bh_push_t      push
);

    localparam logic [3:0] LAST_POS = 4'(SHA1BH_WORDS - 1);

    logic [3:0]  pos_reg;
    logic [3:0]  pos_eff;
    logic [31:0] buf_reg [SHA1BH_WORDS];
    logic        init_reg;
    logic        accept;

    assign pos_eff       = first_block ? 4'd0 : pos_reg;
    assign message_ready = !queue_full || (pos_reg != LAST_POS);
    assign accept        = message_valid && message_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= '0;
        else if (accept)
            pos_reg <= pos_eff + 4'd1;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            buf_reg[pos_eff] <= message_word;
            if (pos_eff == 4'd0)
                init_reg <= first_block;
        end
    end

    // block goes out together with its sixteenth word
    always_comb
    begin
        push.valid     = accept && (pos_eff == LAST_POS);
        push.blk.init  = init_reg;
        push.blk.fin   = end_of_message;
        for (int j = 0; j < SHA1BH_WORDS; j++)
            push.blk.words[j] = (j == SHA1BH_WORDS - 1) ? message_word : buf_reg[j];
    end

endmodule

`default_nettype wire

// File: design/sha1bh_fifo.sv
// sha1bh_fifo: short block queue between the front and the compression engine
// depends on sha1bh_pkg for the block type
`default_nettype none

module sha1bh_fifo
    import sha1bh_pkg::*;
#(
    parameter int DEPTH = SHA1BH_QUEUE_DEPTH
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire sha1bh_push_t push,
    output logic              full,
    input  wire logic         pop,
    output sha1bh_blk_t       pop_data,
    output logic              empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

    sha1bh_blk_t       mem_reg [DEPTH];
    logic [PW-1:0]     wr_ptr_reg;
    logic [PW-1:0]     rd_ptr_reg;
    logic [CW-1:0]     count_reg;
    logic              do_push;
    logic              do_pop;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push.valid && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push.blk;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + CW'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - CW'(1);
        end
    end

endmodule

`default_nettype wire

// File: design/sha1bh_back.sv
// sha1bh_back: one-round-per-cycle sha-1 compression, chaining words and digest output
// depends on sha1bh_pkg; pops blocks from sha1bh_fifo
`default_nettype none

module sha1bh_back
    import sha1bh_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         queue_empty,
    input  wire sha1bh_blk_t  blk,
    output logic              pop,
    output logic              digest_valid,
    input  wire logic         digest_ready,
    output logic [31:0]       digest_word,
    output logic [2:0]        digest_index,
    output logic              last
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ROUND = 4'b0010,
        ST_FINAL = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    localparam logic [6:0] LAST_RND = 7'(SHA1BH_ROUNDS - 1);
    localparam logic [2:0] LAST_IDX = 3'(SHA1BH_DIGEST - 1);

    state_t      state_reg, state_next;
    logic [6:0]  rnd_reg;
    logic [2:0]  idx_reg;
    logic        fin_reg;
    logic [31:0] cv_reg [SHA1BH_DIGEST];
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0] w_reg [SHA1BH_WORDS];
    logic [31:0] tmp;
    logic [31:0] w_mix;
    logic [31:0] w_new;
    logic        out_xfer;

    assign pop      = (state_reg == ST_IDLE) && !queue_empty;
    assign out_xfer = digest_valid && digest_ready;

    assign tmp   = {a_reg[26:0], a_reg[31:27]} + sha1bh_f(rnd_reg, b_reg, c_reg, d_reg)
                   + e_reg + sha1bh_k(rnd_reg) + w_reg[0];
    assign w_mix = w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0];
    assign w_new = {w_mix[30:0], w_mix[31]};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (pop)
                    state_next = ST_ROUND;
            ST_ROUND:
                if (rnd_reg == LAST_RND)
                    state_next = ST_FINAL;
            ST_FINAL:
                state_next = fin_reg ? ST_EMIT : ST_IDLE;
            ST_EMIT:
                if (out_xfer && idx_reg == LAST_IDX)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rnd_reg   <= '0;
            idx_reg   <= '0;
            for (int i = 0; i < SHA1BH_DIGEST; i++)
                cv_reg[i] <= SHA1BH_IV[i];
        end
        else
        begin
            state_reg <= state_next;
            if (pop)
            begin
                rnd_reg <= '0;
                idx_reg <= '0;
                if (blk.init)
                    for (int i = 0; i < SHA1BH_DIGEST; i++)
                        cv_reg[i] <= SHA1BH_IV[i];
            end
            if (state_reg == ST_ROUND)
                rnd_reg <= rnd_reg + 7'd1;
            if (state_reg == ST_FINAL)
            begin
                cv_reg[0] <= cv_reg[0] + a_reg;
                cv_reg[1] <= cv_reg[1] + b_reg;
                cv_reg[2] <= cv_reg[2] + c_reg;
                cv_reg[3] <= cv_reg[3] + d_reg;
                cv_reg[4] <= cv_reg[4] + e_reg;
            end
            if (state_reg == ST_EMIT && out_xfer && idx_reg != LAST_IDX)
                idx_reg <= idx_reg + 3'd1;
        end
    end

    // working variables and schedule window
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            fin_reg <= blk.fin;
            a_reg   <= blk.init ? SHA1BH_IV[0] : cv_reg[0];
            b_reg   <= blk.init ? SHA1BH_IV[1] : cv_reg[1];
            c_reg   <= blk.init ? SHA1BH_IV[2] : cv_reg[2];
            d_reg   <= blk.init ? SHA1BH_IV[3] : cv_reg[3];
            e_reg   <= blk.init ? SHA1BH_IV[4] : cv_reg[4];
            for (int j = 0; j < SHA1BH_WORDS; j++)
                w_reg[j] <= blk.words[j];
        end
        else if (state_reg == ST_ROUND)
        begin
            a_reg <= tmp;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
            for (int j = 0; j < SHA1BH_WORDS - 1; j++)
                w_reg[j] <= w_reg[j + 1];
            w_reg[SHA1BH_WORDS - 1] <= w_new;
        end
    end

    assign digest_valid = (state_reg == ST_EMIT);
    assign digest_word  = cv_reg[idx_reg];
    assign digest_index = idx_reg;
    assign last         = (idx_reg == LAST_IDX);

endmodule

`default_nettype wire

// File: design/sha1_block_hash_core.sv
// sha1_block_hash_core: sha-1 compression of a padded message fed as 32-bit big-endian words
// a block's digest word 0 shows once its sixteenth word has been queued and popped into the engine;
// each 16-word block takes a load, 80 rounds and a chaining add in the single round unit, while the
// front keeps taking words until the queue fills; a final block then emits its five digest words
// reset: asynchronous, clears position, queue and engine state; chaining words load the sha-1 iv
// depends on sha1bh_pkg, sha1bh_front, sha1bh_fifo, sha1bh_back
`default_nettype none

module sha1_block_hash_core
    import sha1bh_pkg::*;
#(
    parameter int QUEUE_DEPTH = SHA1BH_QUEUE_DEPTH
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         message_valid,
    output logic              message_ready,
    input  wire logic [31:0]  message_word,
    input  wire logic         first_block,
    input  wire logic         end_of_message,
    output logic              digest_valid,
    input  wire logic         digest_ready,
    output logic [31:0]       digest_word,
    output logic [2:0]        digest_index,
    output logic              last
);

    sha1bh_push_t push;
    sha1bh_blk_t  head_blk;
    logic         queue_full;
    logic         queue_empty;
    logic         pop;

    sha1bh_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .message_valid  (message_valid),
        .message_ready  (message_ready),
        .message_word   (message_word),
        .first_block    (first_block),
        .end_of_message (end_of_message),
        .queue_full     (queue_full),
        .push           (push)
    );

    sha1bh_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (queue_full),
        .pop      (pop),
        .pop_data (head_blk),
        .empty    (queue_empty)
    );

    sha1bh_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .queue_empty  (queue_empty),
        .blk          (head_blk),
        .pop          (pop),
        .digest_valid (digest_valid),
        .digest_ready (digest_ready),
        .digest_word  (digest_word),
        .digest_index (digest_index),
        .last         (last)
    );

endmodule

`default_nettype wire

// File: design/sha1bh_checker.sv
// sha1bh_checker: port-level assertions on the message and digest channels of the hash core
// bound to sha1_block_hash_core; no other dependencies
`default_nettype none

module sha1bh_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        message_valid,
    input wire logic        message_ready,
    input wire logic [31:0] message_word,
    input wire logic        first_block,
    input wire logic        end_of_message,
    input wire logic        digest_valid,
    input wire logic        digest_ready,
    input wire logic [31:0] digest_word,
    input wire logic [2:0]  digest_index,
    input wire logic        last
);

    // stalled message word holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        message_valid && !message_ready |=> message_valid && $stable(message_word)
            && $stable(first_block) && $stable(end_of_message))
        else $error("message word changed while stalled");

    // stalled digest word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid && !digest_ready |=> digest_valid && $stable(digest_word)
            && $stable(digest_index))
        else $error("digest word changed while stalled");

    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid |-> (last == (digest_index == 3'd4)) && (digest_index <= 3'd4))
        else $error("bad digest index or last flag");

    // digest words follow back to back in index order
    a_seq: assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid && digest_ready && !last |=>
            digest_valid && (digest_index == $past(digest_index) + 3'd1))
        else $error("digest sequence broken");

    a_end: assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid && digest_ready && last |=> !digest_valid)
        else $error("digest word after last");

endmodule

bind sha1_block_hash_core sha1bh_checker u_sha1bh_checker (.*);

`default_nettype wire

// File: verif/testbench.sv
// testbench for sha1_block_hash_core: feeds message words with random bursts and gaps,
// predicts each five-word sha-1 digest in-line and checks every digest transfer in order
// depends on sha1bh_pkg (initial chaining values) and design/sha1_block_hash_core.sv
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sha1bh_pkg::*;

    typedef struct {
        logic [31:0] word;
        logic        first;
        logic        fin;
    } msg_word_t;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_t;

    localparam logic [31:0] ROUND_K [4] = '{
        32'h5A82_7999, 32'h6ED9_EBA1, 32'h8F1B_BCDC, 32'hCA62_C1D6
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        message_valid = 1'b0;
    logic        message_ready;
    logic [31:0] message_word = '0;
    logic        first_block = 1'b0;
    logic        end_of_message = 1'b0;
    logic        digest_valid;
    logic        digest_ready = 1'b0;
    logic [31:0] digest_word;
    logic [2:0]  digest_index;
    logic        last;

    msg_word_t   word_pending[$];
    digest_t     digest_expect[$];

    logic [31:0] chain_h [5];
    logic [31:0] block_w [16];
    logic [3:0]  fill_pos;

    int fail_count = 0;
    int burst_left = 8;
    int gap_left   = 0;
    int ready_left = 0;
    int stall_left = 0;

    sha1_block_hash_core DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .message_valid  (message_valid),
        .message_ready  (message_ready),
        .message_word   (message_word),
        .first_block    (first_block),
        .end_of_message (end_of_message),
        .digest_valid   (digest_valid),
        .digest_ready   (digest_ready),
        .digest_word    (digest_word),
        .digest_index   (digest_index),
        .last           (last)
    );

    always #5 clk = ~clk;

    function automatic logic [31:0] rol32(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic logic [31:0] rand_word();
        logic [31:0] w;
        case ($urandom_range(0, 11))
            0:       w = 32'h0000_0000;
            1:       w = 32'hFFFF_FFFF;
            default: w = $urandom();
        endcase
        return w;
    endfunction

    // stores one word; on the sixteenth runs the compression and queues the digest if final
    task automatic absorb_word(input msg_word_t m);
        logic [31:0] sched [80];
        logic [31:0] a, b, c, d, e, f, tmp;
        digest_t     dg;
        if (m.first) begin
            for (int i = 0; i < 5; i++)
                chain_h[i] = SHA1BH_IV[i];
            fill_pos = '0;
        end
        block_w[fill_pos] = m.word;
        if (fill_pos != 4'd15) begin
            fill_pos = fill_pos + 4'd1;
        end
        else begin
            fill_pos = '0;
            for (int t = 0; t < 16; t++)
                sched[t] = block_w[t];
            for (int t = 16; t < 80; t++)
                sched[t] = rol32(sched[t-3] ^ sched[t-8] ^ sched[t-14] ^ sched[t-16], 1);
            a = chain_h[0];
            b = chain_h[1];
            c = chain_h[2];
            d = chain_h[3];
            e = chain_h[4];
            for (int t = 0; t < 80; t++)
            begin
                if (t < 20)
                    f = (b & c) | (~b & d);
                else if (t >= 40 && t < 60)
                    f = (b & c) | (b & d) | (c & d);
                else
                    f = b ^ c ^ d;
                tmp = rol32(a, 5) + f + e + ROUND_K[t / 20] + sched[t];
                e = d;
                d = c;
                c = rol32(b, 30);
                b = a;
                a = tmp;
            end
            chain_h[0] = chain_h[0] + a;
            chain_h[1] = chain_h[1] + b;
            chain_h[2] = chain_h[2] + c;
            chain_h[3] = chain_h[3] + d;
            chain_h[4] = chain_h[4] + e;
            if (m.fin) begin
                for (int k = 0; k < 5; k++)
                begin
                    dg.word  = chain_h[k];
                    dg.index = k[2:0];
                    dg.last  = (k == 4);
                    digest_expect.push_back(dg);
                end
            end
        end
    endtask

    task automatic add_word(input logic [31:0] w, input logic first, input logic fin);
        msg_word_t m;
        m.word  = w;
        m.first = first;
        m.fin   = fin;
        word_pending.push_back(m);
    endtask

    initial
    begin
        int sel;
        int nblk;
        int n;
        logic fresh;
        for (int i = 0; i < 5; i++)
            chain_h[i] = SHA1BH_IV[i];
        fill_pos = '0;

        // end flag before a full block is ignored, then a first flag mid-block restarts
        add_word(32'hFFFF_FFFF, 1'b1, 1'b1);
        add_word(32'h0000_0000, 1'b0, 1'b0);
        add_word(32'h1234_5678, 1'b0, 1'b1);
        for (int i = 0; i < 16; i++)
            add_word(i[0] ? 32'h0000_0000 : 32'hFFFF_FFFF, i == 0, i == 15);

        while (word_pending.size() < 360)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 70) begin
                // well-formed message, sometimes chained on from the previous digest
                nblk  = ($urandom_range(0, 9) < 6) ? 1 : $urandom_range(2, 3);
                fresh = ($urandom_range(0, 6) != 0);
                for (int b = 0; b < nblk; b++)
                    for (int i = 0; i < 16; i++)
                        add_word(rand_word(), (b == 0 && i == 0) ? fresh : 1'b0,
                                 (i == 15) ? (b == nblk - 1) : ($urandom_range(0, 19) == 0));
            end
            else if (sel < 85) begin
                // message abandoned part way through a block
                n = $urandom_range(1, 15);
                for (int i = 0; i < n; i++)
                    add_word(rand_word(), i == 0, 1'($urandom_range(0, 1)));
            end
            else begin
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++)
                    add_word(rand_word(), $urandom_range(0, 3) == 0,
                             1'($urandom_range(0, 1)));
            end
        end
    end

    // sender: bursts of random length separated by random gaps
    always @(posedge clk or negedge rst_n)
    begin : drive_words
        msg_word_t sent;
        msg_word_t nxt;
        if (!rst_n) begin
            message_valid  <= 1'b0;
            message_word   <= '0;
            first_block    <= 1'b0;
            end_of_message <= 1'b0;
        end
        else if (!message_valid || message_ready) begin
            if (message_valid) begin
                sent.word  = message_word;
                sent.first = first_block;
                sent.fin   = end_of_message;
                absorb_word(sent);
            end
            if (gap_left > 0) begin
                gap_left = gap_left - 1;
                message_valid <= 1'b0;
            end
            else if (word_pending.size() > 0) begin
                nxt = word_pending.pop_front();
                message_valid  <= 1'b1;
                message_word   <= nxt.word;
                first_block    <= nxt.first;
                end_of_message <= nxt.fin;
                burst_left = burst_left - 1;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            else begin
                message_valid <= 1'b0;
            end
        end
    end

    // receiver: checks each digest transfer and stalls in runs of its own
    always @(posedge clk or negedge rst_n)
    begin : check_digest
        digest_t exp_d;
        if (!rst_n) begin
            digest_ready <= 1'b0;
        end
        else begin
            if (digest_valid && digest_ready) begin
                if (digest_expect.size() == 0) begin
                    $error("unexpected digest transfer: word %h index %0d last %b",
                           digest_word, digest_index, last);
                    fail_count = fail_count + 1;
                end
                else begin
                    exp_d = digest_expect.pop_front();
                    if (digest_word !== exp_d.word) begin
                        $error("digest_word: expected %h, actual %h", exp_d.word, digest_word);
                        fail_count = fail_count + 1;
                    end
                    if (digest_index !== exp_d.index) begin
                        $error("digest_index: expected %0d, actual %0d",
                               exp_d.index, digest_index);
                        fail_count = fail_count + 1;
                    end
                    if (last !== exp_d.last) begin
                        $error("last: expected %b, actual %b", exp_d.last, last);
                        fail_count = fail_count + 1;
                    end
                end
            end
            if (ready_left > 0) begin
                ready_left = ready_left - 1;
                digest_ready <= 1'b1;
            end
            else if (stall_left > 0) begin
                stall_left = stall_left - 1;
                digest_ready <= 1'b0;
            end
            else begin
                ready_left = $urandom_range(1, 12);
                stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
                digest_ready <= 1'b1;
            end
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        do
            @(posedge clk);
        while (word_pending.size() != 0 || message_valid);
        while (digest_expect.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire
